/* sv/rlrc_pkg.sv */
// Rectifier level relay controller: shared package.
// Holds widths, limits, register indexes, band and state codes, and the
// command/status structs between controller and datapath. No dependencies.
package rlrc_pkg;

  // Item field widths and averaging
  localparam int SAMPLE_BITS = 10;
  localparam int AVG_SAMPLES = 10;
  localparam int CFG_W       = 16;
  localparam int VOLTS_W     = 17;
  localparam int BAND_W      = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int QCNT_W      = 3;
  localparam int DRIVE_W     = 5;

  // Scaling and qualification limits
  localparam int SCALE_MUL  = 100;
  localparam int LOW_VOLTS  = 100;
  localparam int LOW_LIMIT  = 5;
  localparam int BAND_LIMIT = 4;
  localparam int FLAG_LIMIT = 5;

  // Derived widths
  localparam int CNT_W  = $clog2(AVG_SAMPLES + 1);
  localparam int SUM_W  = $clog2(AVG_SAMPLES * ((1 << SAMPLE_BITS) - 1) + 1);
  localparam int PROD_W = SAMPLE_BITS + $clog2(SCALE_MUL);
  localparam int NUM_A  = (SUM_W > PROD_W) ? SUM_W : PROD_W;
  localparam int NUM_W  = (NUM_A > VOLTS_W) ? NUM_A : VOLTS_W;
  localparam int STEP_W = $clog2(NUM_W);

  localparam logic [NUM_W-1:0] VOLTS_MAX = NUM_W'((1 << VOLTS_W) - 1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VOLT_HIGH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VOLT_LOW   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_CALIB = 2'd2;

  // Configuration reset values
  localparam logic [CFG_W-1:0] VOLT_HIGH_RST  = 16'd128;
  localparam logic [CFG_W-1:0] VOLT_LOW_RST   = 16'd121;
  localparam logic [CFG_W-1:0] RECT_CALIB_RST = 16'd682;

  // Drive latch bit positions
  localparam int DRV_RELAY_ONE = 0;
  localparam int DRV_RELAY_TWO = 1;
  localparam int DRV_LAMP_ONE  = 2;
  localparam int DRV_LAMP_TWO  = 3;
  localparam int DRV_BOOST     = 4;

  typedef enum logic [BAND_W-1:0] {
    BAND_LOW    = 2'd0,
    BAND_UNDER1 = 2'd1,
    BAND_OVER1  = 2'd2,
    BAND_OVER2  = 2'd3
  } band_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIVIDE,
    ST_COMMIT,
    ST_EMIT
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic div_start;
    logic div_step;
    logic commit;
    logic emit;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_div;
  } dp_stat_t;

endpackage

/* sv/rectifier_level_relay_controller.sv */
// Rectifier level relay controller: top level.
// A sample item that does not close the window, or a tick with a zero divisor, goes
// from load straight to commit and emit; any other tick or a window-closing sample
// first runs the 17-step restoring divider, one bit a cycle.
// Items are taken one at a time; the next item is taken while a result waits.
// Reset (synchronous, rst high) restores registers 128/121/682, clears sums, counts,
// flags and drives, and sets the band to over-voltage two.
module rectifier_level_relay_controller (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [rlrc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [rlrc_pkg::CFG_W-1:0]             cfg_data,
  input  logic                                  item_valid,
  output logic                                  item_ready,
  input  logic                                  command,
  input  logic [rlrc_pkg::SAMPLE_BITS-1:0]       rect_sample,
  input  logic                                  mains_pin,
  input  logic                                  boost_pin,
  output logic                                  result_valid,
  input  logic                                  result_ready,
  output logic                                  relay_one,
  output logic                                  relay_two,
  output logic                                  lamp_one,
  output logic                                  lamp_two,
  output logic                                  boost_drive,
  output logic [rlrc_pkg::BAND_W-1:0]            band,
  output logic                                  mains_failed,
  output logic                                  boost_active,
  output logic [rlrc_pkg::VOLTS_W-1:0]           rect_volts
);
  import rlrc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequence the items
  rlrc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  // Compute and hold the results
  rlrc_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .command      (command),
    .rect_sample  (rect_sample),
    .mains_pin    (mains_pin),
    .boost_pin    (boost_pin),
    .cmd          (cmd),
    .stat         (stat),
    .relay_one    (relay_one),
    .relay_two    (relay_two),
    .lamp_one     (lamp_one),
    .lamp_two     (lamp_two),
    .boost_drive  (boost_drive),
    .band         (band),
    .mains_failed (mains_failed),
    .boost_active (boost_active),
    .rect_volts   (rect_volts)
  );

endmodule

/* sv/rlrc_ctrl.sv */
// Rectifier level relay controller: sequencing state machine.
// Drives the item handshake, the divider step count and the result slot.
// Depends on rlrc_pkg.
module rlrc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  output logic              result_valid,
  input  logic              result_ready,
  input  rlrc_pkg::dp_stat_t stat,
  output rlrc_pkg::dp_cmd_t  cmd
);
  import rlrc_pkg::*;

  ctrl_state_t       state, state_next;
  logic [STEP_W-1:0] step_cnt, step_cnt_next;
  logic              result_valid_next;

  // Hold state, step count and result flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      step_cnt     <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      step_cnt     <= step_cnt_next;
      result_valid <= result_valid_next;
    end
  end

  // Advance through capture, divide, commit and emit
  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    cmd           = '0;
    item_ready    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (stat.need_div) begin
          cmd.div_start = 1'b1;
          step_cnt_next = STEP_W'(NUM_W - 1);
          state_next    = ST_DIVIDE;
        end else begin
          state_next = ST_COMMIT;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (step_cnt == '0) begin
          state_next = ST_COMMIT;
        end else begin
          step_cnt_next = step_cnt - 1'b1;
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!result_valid || result_ready) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Set the result flag on emit, drop it when taken
  always_comb begin
    if (cmd.emit) begin
      result_valid_next = 1'b1;
    end else if (result_ready) begin
      result_valid_next = 1'b0;
    end else begin
      result_valid_next = result_valid;
    end
  end

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> state == ST_LOAD)
    else $error("accepted item did not move to load");

  a_div_ends: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIVIDE && step_cnt == '0 |=> state == ST_COMMIT)
    else $error("divide did not end after last step");

  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !result_valid || result_ready)
    else $error("result overwritten before taken");

endmodule

/* sv/rlrc_datapath.sv */
// Rectifier level relay controller: datapath.
// Holds config registers, sample averaging, the shared restoring divider,
// band qualification, flag counters, drive latches and the result register.
// Depends on rlrc_pkg.
module rlrc_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [rlrc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [rlrc_pkg::CFG_W-1:0]             cfg_data,
  input  logic                                  command,
  input  logic [rlrc_pkg::SAMPLE_BITS-1:0]       rect_sample,
  input  logic                                  mains_pin,
  input  logic                                  boost_pin,
  input  rlrc_pkg::dp_cmd_t                      cmd,
  output rlrc_pkg::dp_stat_t                     stat,
  output logic                                  relay_one,
  output logic                                  relay_two,
  output logic                                  lamp_one,
  output logic                                  lamp_two,
  output logic                                  boost_drive,
  output logic [rlrc_pkg::BAND_W-1:0]            band,
  output logic                                  mains_failed,
  output logic                                  boost_active,
  output logic [rlrc_pkg::VOLTS_W-1:0]           rect_volts
);
  import rlrc_pkg::*;

  // Configuration
  logic [CFG_W-1:0] volt_high, volt_low, rect_calib;

  // Captured item
  logic                   cmd_q, mains_q, boost_q;
  logic [SAMPLE_BITS-1:0] sample_q;

  // Block state
  logic [CNT_W-1:0]       sample_count;
  logic [SUM_W-1:0]       sample_sum;
  logic [SAMPLE_BITS-1:0] sample_average;
  logic [VOLTS_W-1:0]     scaled_volts;
  band_t                  current_band;
  logic [QCNT_W-1:0]      band_cnt [4];
  logic [QCNT_W-1:0]      mains_count, boost_count;
  logic                   mains_flag, boost_flag;
  logic [DRIVE_W-1:0]     drive;

  // Divider
  logic [CFG_W-1:0]  divisor;
  logic [CFG_W-1:0]  rem;
  logic [NUM_W-1:0]  quo;
  logic [PROD_W-1:0] prod;
  logic [CFG_W:0]    trial;
  logic [CFG_W+1:0]  diff;
  logic              neg;

  // Tick results
  logic [VOLTS_W-1:0] scaled_next;
  band_t              sel;
  logic [QCNT_W-1:0]  lim;
  band_t              band_next;
  logic [DRIVE_W-1:0] drive_next;
  logic [QCNT_W:0]    mains_upd, boost_upd;

  // Saturating up/down counter with a flag at either end
  function automatic logic [QCNT_W:0] count_flag(input logic up,
                                                 input logic [QCNT_W-1:0] cnt,
                                                 input logic flag);
    logic [QCNT_W-1:0] c;
    logic              f;
    c = cnt;
    f = flag;
    if (up) begin
      if (cnt < QCNT_W'(FLAG_LIMIT)) c = cnt + 1'b1;
      else f = 1'b1;
    end else begin
      if (cnt != '0) c = cnt - 1'b1;
      else f = 1'b0;
    end
    return {c, f};
  endfunction

  // Divide only when a tick has a nonzero divisor or the sample window is full
  assign stat.need_div = cmd_q ? (rect_calib != '0)
                               : (sample_count == CNT_W'(AVG_SAMPLES));

  assign prod  = PROD_W'(sample_average) * PROD_W'(SCALE_MUL);
  assign trial = {rem, quo[NUM_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, divisor};
  assign neg   = diff[CFG_W+1];

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      volt_high  <= VOLT_HIGH_RST;
      volt_low   <= VOLT_LOW_RST;
      rect_calib <= RECT_CALIB_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VOLT_HIGH:  volt_high  <= cfg_data;
        REG_VOLT_LOW:   volt_low   <= cfg_data;
        REG_RECT_CALIB: rect_calib <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture the item and run the divider, one quotient bit per step
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_q    <= command;
      sample_q <= rect_sample;
      mains_q  <= mains_pin;
      boost_q  <= boost_pin;
    end
    if (cmd.div_start) begin
      rem     <= '0;
      quo     <= cmd_q ? NUM_W'(prod) : NUM_W'(sample_sum);
      divisor <= cmd_q ? rect_calib : CFG_W'(AVG_SAMPLES);
    end else if (cmd.div_step) begin
      rem <= neg ? trial[CFG_W-1:0] : diff[CFG_W-1:0];
      quo <= {quo[NUM_W-2:0], ~neg};
    end
  end

  // Scale, select band and work out drives and flags for a tick
  always_comb begin
    if (rect_calib == '0 || quo > VOLTS_MAX) begin
      scaled_next = VOLTS_MAX[VOLTS_W-1:0];
    end else begin
      scaled_next = quo[VOLTS_W-1:0];
    end

    priority if (scaled_next <= VOLTS_W'(LOW_VOLTS)) begin
      sel = BAND_LOW;
      lim = QCNT_W'(LOW_LIMIT);
    end else if (scaled_next < VOLTS_W'(volt_low)) begin
      sel = BAND_UNDER1;
      lim = QCNT_W'(BAND_LIMIT);
    end else if (scaled_next < VOLTS_W'(volt_high)) begin
      sel = BAND_OVER1;
      lim = QCNT_W'(BAND_LIMIT);
    end else begin
      sel = BAND_OVER2;
      lim = QCNT_W'(BAND_LIMIT);
    end

    band_next = (band_cnt[sel] < lim) ? current_band : sel;

    drive_next = '0;
    if (!mains_flag) begin
      unique case (band_next)
        BAND_LOW, BAND_UNDER1: begin
          drive_next[DRV_RELAY_ONE] = 1'b1;
          drive_next[DRV_RELAY_TWO] = 1'b1;
          drive_next[DRV_LAMP_ONE]  = 1'b1;
          drive_next[DRV_LAMP_TWO]  = 1'b1;
        end
        BAND_OVER1: begin
          drive_next[DRV_RELAY_ONE] = 1'b1;
          drive_next[DRV_LAMP_ONE]  = 1'b1;
        end
        default: ;
      endcase
      drive_next[DRV_BOOST] = boost_flag;
    end else begin
      drive_next[DRV_BOOST] = drive[DRV_BOOST];
    end

    mains_upd = count_flag(mains_q, mains_count, mains_flag);
    boost_upd = count_flag(~boost_q, boost_count, boost_flag);
  end

  // Commit sample or tick updates to the block state
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count   <= '0;
      sample_sum     <= '0;
      sample_average <= '0;
      scaled_volts   <= '0;
      current_band   <= BAND_OVER2;
      for (int i = 0; i < 4; i++) band_cnt[i] <= '0;
      mains_count    <= '0;
      mains_flag     <= 1'b0;
      boost_count    <= '0;
      boost_flag     <= 1'b0;
      drive          <= '0;
    end else if (cmd.commit) begin
      if (!cmd_q) begin
        if (sample_count < CNT_W'(AVG_SAMPLES)) begin
          sample_sum   <= sample_sum + SUM_W'(sample_q);
          sample_count <= sample_count + 1'b1;
        end else begin
          sample_average <= quo[SAMPLE_BITS-1:0];
          sample_sum     <= '0;
          sample_count   <= '0;
        end
      end else begin
        scaled_volts <= scaled_next;
        for (int i = 0; i < 4; i++) begin
          if (band_t'(i) != sel) begin
            band_cnt[i] <= '0;
          end else if (band_cnt[i] < lim) begin
            band_cnt[i] <= band_cnt[i] + 1'b1;
          end
        end
        current_band <= band_next;
        drive        <= drive_next;
        mains_count  <= mains_upd[QCNT_W:1];
        mains_flag   <= mains_upd[0];
        boost_count  <= boost_upd[QCNT_W:1];
        boost_flag   <= boost_upd[0];
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      relay_one    <= drive[DRV_RELAY_ONE];
      relay_two    <= drive[DRV_RELAY_TWO];
      lamp_one     <= drive[DRV_LAMP_ONE];
      lamp_two     <= drive[DRV_LAMP_TWO];
      boost_drive  <= drive[DRV_BOOST];
      band         <= current_band;
      mains_failed <= mains_flag;
      boost_active <= boost_flag;
      rect_volts   <= scaled_volts;
    end
  end

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> rem < divisor)
    else $error("divider remainder not below divisor");

  a_low_count_bound: assert property (@(posedge clk) disable iff (rst)
    band_cnt[BAND_LOW] <= QCNT_W'(LOW_LIMIT))
    else $error("low band count past its limit");

  a_fail_clears_lamps: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && cmd_q && mains_flag |=>
      drive[DRV_RELAY_ONE] == 1'b0 && drive[DRV_LAMP_ONE] == 1'b0)
    else $error("drives not cleared during mains failure");

endmodule

/* tb/rectifier_level_relay_controller_test.sv */
// Testbench for the rectifier level relay controller: sample and tick items in,
// one status item out per input, checked against an in-bench charger model.
// Depends on rlrc_pkg and the rectifier_level_relay_controller top level.
module rectifier_level_relay_controller_test;
  import rlrc_pkg::*;

  localparam int HALF_PERIOD   = 5;
  localparam int RESET_CYCLES  = 4;
  localparam int RANDOM_ITEMS  = 1930;
  localparam int NUM_PHASES    = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 30;
  localparam int LIMIT_CYCLES  = 600000;
  localparam int VOLTS_TOP     = (1 << VOLTS_W) - 1;
  localparam int SAMPLE_TOP    = (1 << SAMPLE_BITS) - 1;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;
  // Index with no register behind it; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic               relay_one;
    logic               relay_two;
    logic               lamp_one;
    logic               lamp_two;
    logic               boost_drive;
    band_t              band;
    logic               mains_failed;
    logic               boost_active;
    logic [VOLTS_W-1:0] rect_volts;
  } status_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  // One line of the directed script: an item, or a register write
  typedef struct packed {
    row_kind_t             kind;
    logic                  cmd;
    logic [SAMPLE_BITS-1:0] smp;
    logic                  mp;
    logic                  bp;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_W-1:0]      data;
    logic                  typed;
    status_t               want;
  } row_t;

  // Block ports
  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;
  logic                   item_valid = 1'b0;
  logic                   item_ready;
  logic                   command = 1'b0;
  logic [SAMPLE_BITS-1:0] rect_sample = '0;
  logic                   mains_pin = 1'b0;
  logic                   boost_pin = 1'b1;
  logic                   result_valid;
  logic                   result_ready = 1'b0;
  logic                   relay_one;
  logic                   relay_two;
  logic                   lamp_one;
  logic                   lamp_two;
  logic                   boost_drive;
  logic [BAND_W-1:0]      band;
  logic                   mains_failed;
  logic                   boost_active;
  logic [VOLTS_W-1:0]     rect_volts;

  // Predicted charger state and register copies
  logic [CFG_W-1:0]       exp_high;
  logic [CFG_W-1:0]       exp_low;
  logic [CFG_W-1:0]       exp_calib;
  logic [3:0]             acc_count;
  logic [13:0]            acc_sum;
  logic [SAMPLE_BITS-1:0] acc_avg;
  logic [VOLTS_W-1:0]     exp_volts;
  band_t                  exp_band;
  logic [QCNT_W-1:0]      band_qual [4];
  logic [2:0]             mains_cnt;
  logic [2:0]             boost_cnt;
  logic                   mains_flag;
  logic                   boost_flag;
  logic [DRIVE_W-1:0]     drive;

  status_t pending_status [$];
  int      errors = 0;
  int      results_seen = 0;
  int      items_sent = 0;
  logic    calm = 1'b0;
  logic    mains_on = 1'b0;
  logic    boost_on = 1'b0;
  int      hold_asks = 0;
  int      holds_started = 0;
  int      hold_left = 0;

  rectifier_level_relay_controller uut (.*);

  always #HALF_PERIOD clk = ~clk;

  // Saturating up/down qualifier for the mains and boost flags
  task automatic bump_flag(input logic up, inout logic [2:0] cnt, inout logic flg);
    if (up) begin
      if (cnt < FLAG_LIMIT) cnt = cnt + 1'b1;
      else flg = 1'b1;
    end else begin
      if (cnt > 0) cnt = cnt - 1'b1;
      else flg = 1'b0;
    end
  endtask

  // Advance the charger state by one accepted item
  task automatic step_charger(input logic cmd, input logic [SAMPLE_BITS-1:0] smp,
                              input logic mp, input logic bp);
    longint     quot;
    band_t      pick;
    int         lim;
    int         b;
    logic [3:0] lamps;
    if (cmd == CMD_SAMPLE) begin
      if (acc_count < AVG_SAMPLES) begin
        acc_sum = acc_sum + 14'(smp);
        acc_count = acc_count + 1'b1;
      end else begin
        acc_avg = SAMPLE_BITS'(acc_sum / AVG_SAMPLES);
        acc_sum = '0;
        acc_count = '0;
      end
    end else begin
      // Scale the average, saturating; a zero divisor reads as full scale
      if (exp_calib == 0) quot = VOLTS_TOP;
      else quot = (longint'(acc_avg) * SCALE_MUL) / exp_calib;
      if (quot > VOLTS_TOP) quot = VOLTS_TOP;
      exp_volts = quot[VOLTS_W-1:0];

      // Sort into a band; checks run in this order even with inverted thresholds
      if (exp_volts <= LOW_VOLTS) begin
        pick = BAND_LOW;
        lim = LOW_LIMIT;
      end else if (exp_volts < exp_low) begin
        pick = BAND_UNDER1;
        lim = BAND_LIMIT;
      end else if (exp_volts < exp_high) begin
        pick = BAND_OVER1;
        lim = BAND_LIMIT;
      end else begin
        pick = BAND_OVER2;
        lim = BAND_LIMIT;
      end
      for (b = 0; b < 4; b++)
        if (b != pick) band_qual[b] = '0;
      if (band_qual[pick] < lim) band_qual[pick] = band_qual[pick] + 1'b1;
      else exp_band = pick;

      // Drive from the flags as they stood before this tick
      if (!mains_flag) begin
        case (exp_band)
          BAND_LOW, BAND_UNDER1: lamps = 4'b1111;
          BAND_OVER1:            lamps = 4'b0101;
          default:               lamps = 4'b0000;
        endcase
        drive = {boost_flag, lamps};
      end else begin
        drive = drive & DRIVE_W'(1 << DRV_BOOST);
      end

      bump_flag(mp, mains_cnt, mains_flag);
      bump_flag(!bp, boost_cnt, boost_flag);
    end
  endtask

  function automatic status_t latched_status();
    status_t s;
    s.relay_one    = drive[DRV_RELAY_ONE];
    s.relay_two    = drive[DRV_RELAY_TWO];
    s.lamp_one     = drive[DRV_LAMP_ONE];
    s.lamp_two     = drive[DRV_LAMP_TWO];
    s.boost_drive  = drive[DRV_BOOST];
    s.band         = exp_band;
    s.mains_failed = mains_flag;
    s.boost_active = boost_flag;
    s.rect_volts   = exp_volts;
    return s;
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    $display("mismatch at result %0d: %s", results_seen, what);
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  // Offer one item, hold it until accepted, then record its expected status
  task automatic send_item(input logic cmd, input logic [SAMPLE_BITS-1:0] smp,
                           input logic mp, input logic bp,
                           input logic typed, input status_t want);
    if (!calm && $urandom_range(99) < 15) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 25)) @(posedge clk);
    end
    item_valid  <= 1'b1;
    command     <= cmd;
    rect_sample <= smp;
    mains_pin   <= mp;
    boost_pin   <= bp;
    do @(posedge clk); while (!item_ready);
    step_charger(cmd, smp, mp, bp);
    pending_status.push_back(typed ? want : latched_status());
    items_sent++;
  endtask

  // Stop offering and wait until every expected item has come back
  task automatic drain();
    item_valid <= 1'b0;
    do @(posedge clk); while (pending_status.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_VOLT_HIGH:  exp_high = data;
      REG_VOLT_LOW:   exp_low = data;
      REG_RECT_CALIB: exp_calib = data;
      default: ;
    endcase
  endtask

  function automatic row_t item_row(input logic cmd, input int smp, input logic mp,
                                    input logic bp);
    row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.cmd  = cmd;
    r.smp  = smp[SAMPLE_BITS-1:0];
    r.mp   = mp;
    r.bp   = bp;
    return r;
  endfunction

  // Item whose status is known outright: all drives and flags off
  function automatic row_t checked_row(input logic cmd, input int smp, input logic mp,
                                       input logic bp, input band_t b, input int volts);
    row_t r;
    r = item_row(cmd, smp, mp, bp);
    r.typed = 1'b1;
    r.want.band = b;
    r.want.rect_volts = volts[VOLTS_W-1:0];
    return r;
  endfunction

  function automatic row_t reg_row(input logic [CFG_IDX_W-1:0] idx, input int data);
    row_t r;
    r = '0;
    r.kind = ROW_REG;
    r.idx  = idx;
    r.data = data[CFG_W-1:0];
    return r;
  endfunction

  // One random phase: program the thresholds, then run averaging sequences
  task automatic run_phase(input int phase, input int stop_at);
    logic [CFG_W-1:0] hi, lo, cal;
    int scaled, goal, need, s, roll, mid;
    logic pressed;
    case (phase)
      0, 7: begin
        hi = VOLT_HIGH_RST;
        lo = VOLT_LOW_RST;
        cal = RECT_CALIB_RST;
      end
      1: begin
        hi = 16'h8000;
        lo = 16'd1;
        cal = 16'd1;
      end
      2: begin
        hi = 16'd1;
        lo = 16'h8000;
        cal = RECT_CALIB_RST;
      end
      4: begin
        hi = 16'd1;
        lo = 16'd1;
        cal = 16'h8000;
      end
      5: begin
        hi = CFG_W'($urandom_range(1, 32768));
        lo = CFG_W'($urandom_range(1, 32768));
        cal = CFG_W'($urandom_range(1, 2000));
      end
      default: begin
        hi = CFG_W'($urandom_range(LOW_VOLTS + 1, 2 * LOW_VOLTS));
        lo = CFG_W'($urandom_range(LOW_VOLTS + 1, hi));
        cal = CFG_W'($urandom_range(400, 1200));
      end
    endcase
    write_reg(REG_VOLT_HIGH, hi);
    write_reg(REG_VOLT_LOW, lo);
    write_reg(REG_RECT_CALIB, cal);
    calm <= (phase == 3);
    mid = (items_sent + stop_at) / 2;
    pressed = 1'b0;

    while (items_sent < stop_at) begin
      // Halfway through, phase 2 starves the output and phase 5 lets everything drain
      if (!pressed && items_sent >= mid) begin
        pressed = 1'b1;
        if (phase == 2) hold_asks <= hold_asks + 1;
        else if (phase == 5) drain();
      end
      roll = $urandom_range(99);
      if (roll < 15) begin
        repeat ($urandom_range(1, 6))
          send_item(1'($urandom_range(0, 1)), SAMPLE_BITS'($urandom_range(0, SAMPLE_TOP)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, '0);
      end else begin
        // Aim the average at a band under the current thresholds
        case ($urandom_range(0, 3))
          0: scaled = $urandom_range(0, LOW_VOLTS);
          1: scaled = (exp_low > LOW_VOLTS + 1) ?
                      $urandom_range(LOW_VOLTS + 1, exp_low - 1) :
                      $urandom_range(LOW_VOLTS + 1, 2 * LOW_VOLTS);
          2: scaled = (exp_high > exp_low) ? $urandom_range(exp_low, exp_high - 1) :
                      $urandom_range(0, VOLTS_TOP);
          default: scaled = $urandom_range(exp_high, exp_high + 40);
        endcase
        if (exp_calib == 0) goal = $urandom_range(0, SAMPLE_TOP);
        else goal = int'((longint'(scaled) * exp_calib) / SCALE_MUL);
        if (goal > SAMPLE_TOP) goal = SAMPLE_TOP;

        // Fill the window and close it; a broken run stops short
        need = AVG_SAMPLES + 1 - int'(acc_count);
        if (roll < 25) need = $urandom_range(0, need);
        repeat (need) begin
          s = goal + int'($urandom_range(0, 4)) - 2;
          if (s < 0) s = 0;
          if (s > SAMPLE_TOP) s = SAMPLE_TOP;
          send_item(CMD_SAMPLE, s[SAMPLE_BITS-1:0], 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 1'b0, '0);
        end

        // Pins hold a level across sequences, with an occasional glitch
        if ($urandom_range(5) == 0) mains_on = !mains_on;
        if ($urandom_range(5) == 0) boost_on = !boost_on;
        repeat ($urandom_range(1, 8))
          send_item(CMD_TICK, SAMPLE_BITS'($urandom_range(0, SAMPLE_TOP)),
                    mains_on ^ ($urandom_range(9) == 0),
                    !(boost_on ^ ($urandom_range(9) == 0)), 1'b0, '0);
      end
    end
  endtask

  // Output side: random stalls, a long hold-off on request, calm stretches
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_asks != holds_started) begin
      holds_started <= hold_asks;
      hold_left <= HOLD_CYCLES;
      result_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      result_ready <= 1'b0;
    end else begin
      result_ready <= calm || ($urandom_range(99) >= 15);
    end
  end

  // Compare each accepted status item with the oldest expectation
  always @(posedge clk) begin : check_results
    status_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_status.size() == 0) begin
        report_mismatch("status item with no input item outstanding");
      end else begin
        want = pending_status.pop_front();
        compare_field("relay_one", relay_one, want.relay_one);
        compare_field("relay_two", relay_two, want.relay_two);
        compare_field("lamp_one", lamp_one, want.lamp_one);
        compare_field("lamp_two", lamp_two, want.lamp_two);
        compare_field("boost_drive", boost_drive, want.boost_drive);
        compare_field("band", band, want.band);
        compare_field("mains_failed", mains_failed, want.mains_failed);
        compare_field("boost_active", boost_active, want.boost_active);
        compare_field("rect_volts", rect_volts, want.rect_volts);
      end
      results_seen++;
    end
  end

  initial begin : stimulus
    row_t rows [$];
    row_t r;
    int   base;
    int   p;
    exp_high   = VOLT_HIGH_RST;
    exp_low    = VOLT_LOW_RST;
    exp_calib  = RECT_CALIB_RST;
    acc_count  = '0;
    acc_sum    = '0;
    acc_avg    = '0;
    exp_volts  = '0;
    exp_band   = BAND_OVER2;
    foreach (band_qual[i]) band_qual[i] = '0;
    mains_cnt  = '0;
    boost_cnt  = '0;
    mains_flag = 1'b0;
    boost_flag = 1'b0;
    drive      = '0;

    // Out of reset everything is off and the band reads over-voltage two
    rows.push_back(checked_row(CMD_SAMPLE, 0, 1'b0, 1'b1, BAND_OVER2, 0));
    rows.push_back(checked_row(CMD_TICK, 0, 1'b0, 1'b1, BAND_OVER2, 0));
    // Full-scale samples fill the window; the extra sample is dropped and closes the average
    repeat (AVG_SAMPLES - 1) rows.push_back(item_row(CMD_SAMPLE, SAMPLE_TOP, 1'b0, 1'b1));
    rows.push_back(item_row(CMD_SAMPLE, 0, 1'b1, 1'b0));
    repeat (3) rows.push_back(item_row(CMD_TICK, 0, 1'b1, 1'b0));
    // Zero divisor reads full scale
    rows.push_back(reg_row(REG_RECT_CALIB, 0));
    rows.push_back(checked_row(CMD_TICK, 0, 1'b0, 1'b1, BAND_OVER2, VOLTS_TOP));
    // Widest thresholds with unit divisor
    rows.push_back(reg_row(REG_VOLT_HIGH, 16'h8000));
    rows.push_back(reg_row(REG_VOLT_LOW, 1));
    rows.push_back(reg_row(REG_RECT_CALIB, 1));
    repeat (2) rows.push_back(item_row(CMD_TICK, SAMPLE_TOP, 1'b1, 1'b0));
    // Inverted thresholds, plus a write to the unused index
    rows.push_back(reg_row(REG_VOLT_HIGH, 1));
    rows.push_back(reg_row(REG_VOLT_LOW, 16'h8000));
    rows.push_back(reg_row(REG_RECT_CALIB, RECT_CALIB_RST));
    rows.push_back(reg_row(REG_SPARE, 16'hFFFF));
    repeat (2) rows.push_back(item_row(CMD_TICK, 0, 1'b1, 1'b0));

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      r = rows[i];
      if (r.kind == ROW_REG) write_reg(r.idx, r.data);
      else send_item(r.cmd, r.smp, r.mp, r.bp, r.typed, r.want);
    end

    base = items_sent;
    for (p = 0; p < NUM_PHASES; p++)
      run_phase(p, base + (p + 1) * RANDOM_ITEMS / NUM_PHASES);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog for a hung handshake
  initial begin : watchdog
    #(LIMIT_CYCLES * 2 * HALF_PERIOD);
    $display("== FAIL ==");
    $finish;
  end

endmodule
